>>> design/wrmf_pkg.sv
package wrmf_pkg;

  localparam int CHANNELS = 4;
  localparam int BYTE_W   = 8;

  typedef logic [CHANNELS-1:0][BYTE_W-1:0] pix_t;

  typedef enum logic [1:0] {
    MODE_MEDIAN = 2'd0,
    MODE_MIN    = 2'd1,
    MODE_MAX    = 2'd2,
    MODE_MEAN   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_WINDOW = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FEED  = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

endpackage

>>> design/wrmf_cell.sv
module wrmf_cell
  import wrmf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic clear_i,
  input  logic in_valid_i,
  input  pix_t in_pix_i,
  output logic out_valid_o,
  output pix_t out_pix_o,
  output pix_t held_o
);

  logic full_q;
  logic ovalid_q;
  pix_t held_q;
  pix_t opix_q;
  pix_t lo;
  pix_t hi;

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      if (in_pix_i[ch] < held_q[ch]) begin
        lo[ch] = in_pix_i[ch];
        hi[ch] = held_q[ch];
      end else begin
        lo[ch] = held_q[ch];
        hi[ch] = in_pix_i[ch];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else if (clear_i) begin
      full_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else if (in_valid_i) begin
      full_q   <= 1'b1;
      ovalid_q <= full_q;
    end else begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !clear_i) begin
      if (!full_q) begin
        held_q <= in_pix_i;
      end else begin
        held_q <= lo;
        opix_q <= hi;
      end
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_pix_o   = opix_q;
  assign held_o      = held_q;

endmodule

>>> design/wrmf_div.sv
module wrmf_div #(
  parameter int SUM_W = 14,
  parameter int DIV_W = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic [7:0]       quot_o
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [STEP_W-1:0] step_q;
  logic [SUM_W-1:0]  quo_q;
  logic [DIV_W-1:0]  rem_q;
  logic [DIV_W-1:0]  div_q;
  logic [DIV_W:0]    trial;
  logic              take;
  logic [DIV_W:0]    diff;

  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign take  = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (start_i) begin
      step_q <= STEP_W'(SUM_W);
    end else if (step_q != '0) begin
      step_q <= step_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (step_q != '0) begin
      quo_q <= {quo_q[SUM_W-2:0], take};
      rem_q <= take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end
  end

  assign quot_o = quo_q[7:0];

endmodule

>>> design/window_rank_mean_filter_top.sv
// Window rank / mean filter over a raster stream of 32-bit pixels.
// Input channel: in_valid_i / in_ready_o with chan0..chan3 and frame_start.
// Output channel: out_valid_o / out_ready_i with res0..res3, centre_col,
// centre_row and frame_end; one word per interior pixel, border pixels give
// nothing. Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 mode, 1 window size, 2 width, 3 height); the user must write only while
// the block is idle, which the block itself does not enforce. A pixel that
// completes no window leaves the block idle. For a pixel that completes an
// n by n window, the n*n window words are read one per cycle from the single
// read port of the line store and stream through a chain of compare-exchange
// cells that sorts them; the mean comes from a 14 step shift-subtract divider
// run in parallel. The result sits in an output register, so a new pixel is
// taken while the receiver stalls; the next window result then waits for that
// register. Reset clears position counters and handshake state and loads the
// register defaults; the line store is not cleared and needs no clearing pass.
module window_rank_mean_filter_top
  import wrmf_pkg::*;
#(
  parameter int MAX_WINDOW = 7,
  parameter int MAX_WIDTH  = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  chan0_i,
  input  logic [7:0]  chan1_i,
  input  logic [7:0]  chan2_i,
  input  logic [7:0]  chan3_i,
  input  logic        frame_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  res0_o,
  output logic [7:0]  res1_o,
  output logic [7:0]  res2_o,
  output logic [7:0]  res3_o,
  output logic [9:0]  centre_col_o,
  output logic [15:0] centre_row_o,
  output logic        frame_end_o
);

  localparam int LINES = MAX_WINDOW;
  localparam int RM_W  = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WV_W  = $clog2(MAX_WIDTH + 1);
  localparam int XW    = (WV_W > 11) ? WV_W : 11;
  localparam int NW    = $clog2(MAX_WINDOW + 1);
  localparam int NX    = (NW > 3) ? NW : 3;
  localparam int NCELL = MAX_WINDOW * MAX_WINDOW;
  localparam int CNT_W = $clog2(NCELL + 1);
  localparam int SUM_W = BYTE_W + CNT_W;
  localparam int DR_W  = $clog2(NCELL + SUM_W + 8);
  localparam int IDX_W = (NCELL > 1) ? $clog2(NCELL) : 1;

  mode_e       mode_q;
  logic [2:0]  wsize_q;
  logic [10:0] width_q;
  logic [15:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_MEDIAN;
      wsize_q  <= 3'd3;
      width_q  <= 11'd1024;
      height_q <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_MODE:   mode_q   <= mode_e'(cfg_data_i[1:0]);
        REG_WINDOW: wsize_q  <= cfg_data_i[2:0];
        REG_WIDTH:  width_q  <= cfg_data_i[10:0];
        REG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [NX-1:0]    nclamp;
  logic [NX-1:0]    nodd;
  logic [NW-1:0]    n_eff;
  logic [NW-1:0]    nm1;
  logic [XW-1:0]    wx;
  logic [XW-1:0]    w_eff;
  logic [15:0]      h_eff;
  logic [CNT_W-1:0] cnt;

  always_comb begin
    nclamp = (NX'(wsize_q) > NX'(MAX_WINDOW)) ? NX'(MAX_WINDOW) : NX'(wsize_q);
    if (nclamp[0]) begin
      nodd = nclamp;
    end else begin
      nodd = (nclamp == '0) ? NX'(1) : nclamp - 1'b1;
    end
    n_eff = NW'(nodd);
    nm1   = n_eff - 1'b1;
    wx    = (XW'(width_q) == '0) ? XW'(1) : XW'(width_q);
    w_eff = (wx > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : wx;
    h_eff = (height_q == '0) ? 16'd1 : height_q;
    cnt   = CNT_W'(n_eff) * CNT_W'(n_eff);
  end

  state_e state_q;
  state_e state_d;

  logic [COL_W-1:0] col_q;
  logic [15:0]      row_q;
  logic [RM_W-1:0]  rm_q;

  logic accept;
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  logic [COL_W-1:0] c0;
  logic [COL_W-1:0] c1;
  logic [16:0]      r0;
  logic [16:0]      r1;
  logic [15:0]      r2;
  logic [RM_W-1:0]  rm0;
  logic [RM_W-1:0]  rm1;
  logic [RM_W-1:0]  rm2;
  logic [XW-1:0]    cn;
  logic [COL_W-1:0] col_d;
  logic [16:0]      rn;
  logic [15:0]      row_d;
  logic [RM_W-1:0]  rm_d;
  logic             emit;
  logic             fend;
  logic [RM_W:0]    ss_sum;
  logic [RM_W-1:0]  slot_start;

  function automatic logic [RM_W-1:0] rm_inc(input logic [RM_W-1:0] v);
    rm_inc = (v == RM_W'(LINES - 1)) ? '0 : v + 1'b1;
  endfunction

  always_comb begin
    c0  = frame_start_i ? '0 : col_q;
    r0  = frame_start_i ? '0 : {1'b0, row_q};
    rm0 = frame_start_i ? '0 : rm_q;
    if (XW'(c0) >= w_eff) begin
      c1  = '0;
      r1  = r0 + 1'b1;
      rm1 = rm_inc(rm0);
    end else begin
      c1  = c0;
      r1  = r0;
      rm1 = rm0;
    end
    if (r1 >= {1'b0, h_eff}) begin
      r2  = '0;
      rm2 = '0;
    end else begin
      r2  = r1[15:0];
      rm2 = rm1;
    end
    emit = (XW'(c1) >= XW'(nm1)) && (r2 >= 16'(nm1));
    fend = (XW'(c1) == w_eff - 1'b1) && (r2 == h_eff - 1'b1);
    cn   = XW'(c1) + 1'b1;
    rn   = {1'b0, r2} + 1'b1;
    if (cn >= w_eff) begin
      col_d = '0;
      if (rn >= {1'b0, h_eff}) begin
        row_d = '0;
        rm_d  = '0;
      end else begin
        row_d = rn[15:0];
        rm_d  = rm_inc(rm2);
      end
    end else begin
      col_d = COL_W'(cn);
      row_d = r2;
      rm_d  = rm2;
    end
    ss_sum     = (RM_W+1)'(rm2) + (RM_W+1)'(LINES) - (RM_W+1)'(nm1);
    slot_start = (ss_sum >= (RM_W+1)'(LINES)) ? RM_W'(ss_sum - (RM_W+1)'(LINES))
                                              : RM_W'(ss_sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      rm_q  <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
      rm_q  <= rm_d;
    end
  end

  pix_t             pix_in;
  logic [31:0]      mem [LINES][MAX_WIDTH];
  logic [COL_W-1:0] fcol_q;
  logic [RM_W-1:0]  fslot_q;
  logic [NW-1:0]    fj_q;
  logic [NW-1:0]    fk_q;
  logic             rvalid_q;
  pix_t             rdata_q;

  assign pix_in = {chan3_i, chan2_i, chan1_i, chan0_i};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem[rm2][c1] <= pix_in;
    end
    if (state_q == ST_FEED) begin
      rdata_q <= mem[fslot_q][fcol_q];
    end
  end

  logic [COL_W-1:0] ic_q;
  logic [15:0]      ir_q;
  logic             ife_q;
  logic             feed_last;
  logic [DR_W-1:0]  drain_q;
  logic             finish;
  logic             load_out;
  logic             out_valid_q;

  assign feed_last = (fj_q == nm1) && (fk_q == nm1);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ic_q    <= c1;
      ir_q    <= r2;
      ife_q   <= fend;
      fj_q    <= '0;
      fk_q    <= '0;
      fslot_q <= slot_start;
      fcol_q  <= c1 - COL_W'(nm1);
    end else if (state_q == ST_FEED) begin
      if (fj_q == nm1) begin
        fj_q    <= '0;
        fk_q    <= fk_q + 1'b1;
        fslot_q <= rm_inc(fslot_q);
        fcol_q  <= ic_q - COL_W'(nm1);
      end else begin
        fj_q   <= fj_q + 1'b1;
        fcol_q <= fcol_q + 1'b1;
      end
    end
  end

  assign finish   = (state_q == ST_DRAIN) && (drain_q >= DR_W'(SUM_W + 3)) &&
                    (drain_q >= DR_W'(cnt) + DR_W'(2));
  assign load_out = finish && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept && emit) state_d = ST_FEED;
      ST_FEED:  if (feed_last) state_d = ST_DRAIN;
      ST_DRAIN: if (load_out) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rvalid_q <= 1'b0;
      drain_q  <= '0;
    end else begin
      state_q  <= state_d;
      rvalid_q <= (state_q == ST_FEED);
      if (state_q != ST_DRAIN) begin
        drain_q <= '0;
      end else if (!finish) begin
        drain_q <= drain_q + 1'b1;
      end
    end
  end

  logic [CHANNELS-1:0][SUM_W-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sum_q <= '0;
    end else if (rvalid_q) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        sum_q[ch] <= sum_q[ch] + SUM_W'(rdata_q[ch]);
      end
    end
  end

  logic                          div_start;
  logic [CHANNELS-1:0][7:0]      quot;

  assign div_start = (state_q == ST_DRAIN) && (drain_q == DR_W'(1));

  for (genvar g = 0; g < CHANNELS; g++) begin : g_div
    wrmf_div #(
      .SUM_W (SUM_W),
      .DIV_W (CNT_W)
    ) u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (div_start),
      .dividend_i (sum_q[g]),
      .divisor_i  (cnt),
      .quot_o     (quot[g])
    );
  end

  logic [NCELL-1:0] cv;
  pix_t             cp   [NCELL];
  pix_t             held [NCELL];

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    wrmf_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .clear_i     (accept),
      .in_valid_i  ((g == 0) ? rvalid_q : cv[(g == 0) ? 0 : g - 1]),
      .in_pix_i    ((g == 0) ? rdata_q : cp[(g == 0) ? 0 : g - 1]),
      .out_valid_o (cv[g]),
      .out_pix_o   (cp[g]),
      .held_o      (held[g])
    );
  end

  logic [IDX_W-1:0] sel;
  pix_t             pick;
  pix_t             res;
  logic [CNT_W-1:0] cm1;

  always_comb begin
    cm1 = cnt - 1'b1;
    unique case (mode_q)
      MODE_MEDIAN: sel = IDX_W'(cm1 >> 1);
      MODE_MIN:    sel = '0;
      MODE_MAX:    sel = IDX_W'(cm1);
      MODE_MEAN:   sel = '0;
      default:     sel = '0;
    endcase
    pick = held[sel];
    res  = (mode_q == MODE_MEAN) ? quot : pick;
  end

  pix_t        res_q;
  logic [9:0]  ccol_q;
  logic [15:0] crow_q;
  logic        fe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      res_q  <= res;
      ccol_q <= 10'(ic_q - COL_W'(nm1 >> 1));
      crow_q <= ir_q - 16'(nm1 >> 1);
      fe_q   <= ife_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign res0_o       = res_q[0];
  assign res1_o       = res_q[1];
  assign res2_o       = res_q[2];
  assign res3_o       = res_q[3];
  assign centre_col_o = ccol_q;
  assign centre_row_o = crow_q;
  assign frame_end_o  = fe_q;

`ifndef ASSERT_OFF
  a_rvalid_after_feed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvalid_q |-> $past(state_q == ST_FEED))
    else $error("line store data without a read");

  a_out_from_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DRAIN))
    else $error("result word outside drain");

  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_IDLE || state_q == ST_FEED))
    else $error("bad state after accept");

  a_div_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (drain_q > DR_W'(SUM_W)))
    else $error("result loaded before divider done");
`endif

endmodule

>>> dv/tb_window_rank_mean_filter_top.sv
`timescale 1ns / 100ps

module tb_window_rank_mean_filter_top;
  import wrmf_pkg::*;

  localparam int WMAX     = 7;
  localparam int LMAX     = 1024;
  localparam int LINES    = WMAX - 1;
  localparam int DRAIN    = 300;
  localparam int LIMIT    = 1000000;

  typedef struct {
    logic [7:0] ch [4];
    logic       fs;
  } pixel_t;

  typedef struct {
    logic [7:0]  ch [4];
    logic [9:0]  col;
    logic [15:0] row;
    logic        fe;
  } window_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  chan0_i = '0, chan1_i = '0, chan2_i = '0, chan3_i = '0;
  logic        frame_start_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  res0_o, res1_o, res2_o, res3_o;
  logic [9:0]  centre_col_o;
  logic [15:0] centre_row_o;
  logic        frame_end_o;

  window_rank_mean_filter_top dut (.*);

  always #6 clk_i = ~clk_i;

  pixel_t      pixel_q [$];
  window_out_t window_q [$];

  bit [31:0] line_mem [LINES][LMAX];
  bit [31:0] win_regs [WMAX][WMAX];
  int unsigned pos_col, pos_row;
  int unsigned cur_mode, cur_win, cur_width, cur_height;

  int errors, pixels_in, windows_out, frames_done, phases;
  int cycles;
  bit long_hold_go;

  function automatic int unsigned chan_filter(int unsigned n, int sh);
    int unsigned vals [49];
    int unsigned cnt, sum, v, j;
    cnt = 0;
    sum = 0;
    for (int k = 0; k < n; k++)
      for (int c = WMAX - n; c < WMAX; c++) begin
        v = (win_regs[k][c] >> sh) & 8'hFF;
        vals[cnt] = v;
        cnt++;
        sum += v;
      end
    if (cur_mode == MODE_MEAN) return sum / cnt;
    for (int i = 1; i < cnt; i++) begin
      v = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > v) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = v;
    end
    if (cur_mode == MODE_MIN) return vals[0];
    if (cur_mode == MODE_MAX) return vals[cnt-1];
    return vals[(cnt-1)/2];
  endfunction

  task automatic predict_pixel(pixel_t p);
    int unsigned n, w, h, t, c, r, rmod, back, slot;
    bit [31:0] pix;
    window_out_t e;
    n = cur_win;
    if (n > WMAX) n = WMAX;
    if (n[0] == 1'b0) n = (n == 0) ? 1 : n - 1;
    w = (cur_width == 0) ? 1 : (cur_width > LMAX ? LMAX : cur_width);
    h = (cur_height == 0) ? 1 : cur_height;
    t = (n - 1) / 2;
    pix = {p.ch[3], p.ch[2], p.ch[1], p.ch[0]};
    if (p.fs) begin
      pos_col = 0;
      pos_row = 0;
    end
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row >= h) pos_row = 0;
    c = pos_col;
    r = pos_row;
    rmod = r % LINES;
    for (int k = 0; k < WMAX; k++)
      for (int j = 0; j < WMAX - 1; j++) win_regs[k][j] = win_regs[k][j+1];
    for (int k = 0; k + 1 < n; k++) begin
      back = (n - 1 - k) % LINES;
      slot = (rmod + LINES - back) % LINES;
      win_regs[k][WMAX-1] = line_mem[slot][c];
    end
    win_regs[n-1][WMAX-1] = pix;
    line_mem[rmod][c] = pix;
    if (c >= n - 1 && r >= n - 1) begin
      for (int i = 0; i < 4; i++) e.ch[i] = 8'(chan_filter(n, 8 * i));
      e.col = 10'(c - t);
      e.row = 16'(r - t);
      e.fe = (c == w - 1 && r == h - 1);
      window_q.push_back(e);
    end
    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= h) pos_row = 0;
    end
  endtask

  // driver: bursts with random gaps
  int burst_left, gap_left;
  always @(posedge clk_i) begin
    pixel_t p;
    logic nv;
    if (rst_ni) begin
      nv = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        p.ch[0] = chan0_i; p.ch[1] = chan1_i; p.ch[2] = chan2_i; p.ch[3] = chan3_i;
        p.fs = frame_start_i;
        predict_pixel(p);
        pixels_in++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pixel_q.size() > 0) begin
          p = pixel_q.pop_front();
          chan0_i <= p.ch[0]; chan1_i <= p.ch[1]; chan2_i <= p.ch[2]; chan3_i <= p.ch[3];
          frame_start_i <= p.fs;
          nv = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      in_valid_i <= nv;
    end
  end

  // receiver: own stall pattern plus one long hold
  int hold_left, pat_left;
  bit pat_busy;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (long_hold_go) begin
        long_hold_go = 1'b0;
        hold_left = 2000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          pat_busy = ($urandom_range(0, 2) == 0);
          pat_left = $urandom_range(5, 200);
        end
        pat_left--;
        out_ready_i <= pat_busy ? ($urandom_range(0, 3) != 0) : 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    window_out_t e;
    logic [7:0] got [4];
    if (rst_ni && out_valid_o && out_ready_i) begin
      got[0] = res0_o; got[1] = res1_o; got[2] = res2_o; got[3] = res3_o;
      windows_out++;
      if (frame_end_o) frames_done++;
      if (window_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word col %0d row %0d", centre_col_o, centre_row_o);
      end else begin
        e = window_q.pop_front();
        if (got != e.ch || centre_col_o != e.col || centre_row_o != e.row
            || frame_end_o != e.fe) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp %h %h %h %h c%0d r%0d e%0b got %h %h %h %h c%0d r%0d e%0b",
                     e.ch[0], e.ch[1], e.ch[2], e.ch[3], e.col, e.row, e.fe,
                     got[0], got[1], got[2], got[3], centre_col_o, centre_row_o, frame_end_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic wait_idle();
    do begin
      while (pixel_q.size() != 0 || in_valid_i || window_q.size() != 0) @(posedge clk_i);
      repeat (DRAIN) @(posedge clk_i);
    end while (pixel_q.size() != 0 || in_valid_i || window_q.size() != 0);
  endtask

  task automatic write_reg(reg_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= 16'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MODE:   cur_mode = val & 2'h3;
      REG_WINDOW: cur_win = val & 3'h7;
      REG_WIDTH:  cur_width = val & 11'h7FF;
      default:    cur_height = val & 16'hFFFF;
    endcase
  endtask

  task automatic configure(mode_e m, int unsigned n, int unsigned w, int unsigned h);
    wait_idle();
    write_reg(REG_MODE, m);
    write_reg(REG_WINDOW, n);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    phases++;
  endtask

  // kind: 0 random, 1 all zero, 2 all ones, 3 alternating extremes
  task automatic queue_pixels(int cnt, int kind, bit noise);
    pixel_t p;
    for (int i = 0; i < cnt; i++) begin
      for (int b = 0; b < 4; b++)
        case (kind)
          1: p.ch[b] = 8'h00;
          2: p.ch[b] = 8'hFF;
          3: p.ch[b] = ((i + b) % 2) ? 8'hFF : 8'h00;
          default: p.ch[b] = 8'($urandom_range(0, 255));
        endcase
      p.fs = (i == 0) || (noise && $urandom_range(0, 60) == 0);
      pixel_q.push_back(p);
    end
  endtask

  initial begin
    int w, h, n, total;
    cur_mode = MODE_MEDIAN; cur_win = 3; cur_width = 1024; cur_height = 1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    configure(MODE_MEDIAN, 3, 3, 3);
    queue_pixels(9, 3, 0);
    configure(MODE_MIN, 1, 1024, 1);
    queue_pixels(4, 2, 0);
    configure(MODE_MAX, 0, 0, 0);
    queue_pixels(2, 1, 0);
    configure(MODE_MEAN, 4, 2047, 65535);
    queue_pixels(5, 2, 0);
    configure(MODE_MEAN, 7, 7, 7);
    queue_pixels(49, 2, 0);
    configure(MODE_MEDIAN, 5, 3, 4);
    queue_pixels(12, 0, 0);
    configure(MODE_MAX, 6, 5, 5);
    queue_pixels(25, 3, 0);

    wait_idle();
    configure(MODE_MEDIAN, 3, 8, 40);
    queue_pixels(320, 0, 0);
    repeat (200) @(posedge clk_i);
    long_hold_go = 1'b1;

    total = 0;
    while (total < 380) begin
      n = $urandom_range(0, 7);
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 10);
      if ($urandom_range(0, 9) == 0) w = $urandom_range(1, 30);
      configure(mode_e'($urandom_range(0, 3)), n, w, h);
      for (int f = $urandom_range(1, 3); f > 0; f--) begin
        queue_pixels(w * h, 0, $urandom_range(0, 4) == 0);
        total += w * h;
      end
    end

    wait_idle();
    $display("%0d pixels in %0d settings, %0d windows checked, %0d frame ends",
             pixels_in, phases, windows_out, frames_done);
    if (errors == 0 && window_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d words missing", errors, window_q.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
design/wrmf_pkg.sv
design/wrmf_cell.sv
design/wrmf_div.sv
design/window_rank_mean_filter_top.sv
dv/tb_window_rank_mean_filter_top.sv
